// ===== src/efadd_pkg.sv =====
// Shared types and constants for the extended float adder.
package efadd_pkg;

    localparam int MANT_W  = 160;
    localparam int EXP_W   = 15;
    localparam int SHAMT_W = 8;
    localparam logic [EXP_W-1:0] EXP_INF = 15'h7FFF;

    typedef struct packed {
        logic        a_sign;
        logic [14:0] a_exp;
        logic [31:0] a_mant_hi;
        logic [63:0] a_mant_mid;
        logic [63:0] a_mant_lo;
        logic        b_sign;
        logic [14:0] b_exp;
        logic [31:0] b_mant_hi;
        logic [63:0] b_mant_mid;
        logic [63:0] b_mant_lo;
    } t_in;

    typedef struct packed {
        logic        sum_sign;
        logic [14:0] sum_exp;
        logic [31:0] sum_mant_hi;
        logic [63:0] sum_mant_mid;
        logic [63:0] sum_mant_lo;
    } t_out;

    // Work carried between stages.
    typedef struct packed {
        logic              special;
        logic [MANT_W-1:0] spec_mant;
        logic              sub;
        logic              sign;
        logic [EXP_W-1:0]  exp;
        logic [MANT_W-1:0] big;
        logic [MANT_W-1:0] lesser;
        logic [SHAMT_W-1:0] shamt;
        logic              flush;
    } t_work;

endpackage

// ===== src/efadd_prep.sv =====
// Stage one: special cases, magnitude compare and operand swap.
module efadd_prep (
    input  efadd_pkg::t_in   i_in,
    output efadd_pkg::t_work o_work
);
    import efadd_pkg::*;

    logic [MANT_W-1:0] ma, mb;
    logic a_nan, b_nan, a_inf, b_inf, sub, a_big, eq;
    logic [EXP_W-1:0] d;

    always_comb begin
        ma = {i_in.a_mant_hi, i_in.a_mant_mid, i_in.a_mant_lo};
        mb = {i_in.b_mant_hi, i_in.b_mant_mid, i_in.b_mant_lo};
        a_nan = (i_in.a_exp == EXP_INF) && (ma != '0);
        b_nan = (i_in.b_exp == EXP_INF) && (mb != '0);
        a_inf = (i_in.a_exp == EXP_INF) && (ma == '0);
        b_inf = (i_in.b_exp == EXP_INF) && (mb == '0);
        sub = i_in.a_sign != i_in.b_sign;
        eq = (i_in.a_exp == i_in.b_exp) && (ma == mb);
        a_big = (i_in.a_exp > i_in.b_exp) || ((i_in.a_exp == i_in.b_exp) && (ma > mb));
        d = '0;
        o_work = '0;
        o_work.sub = sub;
        if (a_nan) begin
            o_work.special = 1'b1;
            o_work.sign = i_in.a_sign;
            o_work.exp = i_in.a_exp;
            o_work.spec_mant = ma;
        end else if (b_nan) begin
            o_work.special = 1'b1;
            o_work.sign = i_in.b_sign;
            o_work.exp = i_in.b_exp;
            o_work.spec_mant = mb;
        end else if (a_inf && b_inf && sub) begin
            o_work.special = 1'b1;
            o_work.exp = EXP_INF;
            o_work.spec_mant = (MANT_W'(1) << 158) | (MANT_W'(1) << 63);
        end else if (a_inf || b_inf) begin
            o_work.special = 1'b1;
            o_work.sign = a_inf ? i_in.a_sign : i_in.b_sign;
            o_work.exp = EXP_INF;
        end else if (sub && eq) begin
            o_work.special = 1'b1;
        end else begin
            if (a_big) begin
                o_work.big = ma;
                o_work.lesser = mb;
                o_work.exp = i_in.a_exp;
                d = i_in.a_exp - i_in.b_exp;
            end else begin
                o_work.big = mb;
                o_work.lesser = ma;
                o_work.exp = i_in.b_exp;
                d = i_in.b_exp - i_in.a_exp;
            end
            o_work.sign = sub ? (a_big ? i_in.a_sign : i_in.b_sign) : i_in.a_sign;
            o_work.flush = d > EXP_W'(MANT_W - 1);
            o_work.shamt = d[SHAMT_W-1:0];
        end
    end

endmodule

// ===== src/efadd_norm.sv =====
// Final stage: carry handling and left normalization of a difference.
module efadd_norm (
    input  logic                          i_special,
    input  logic [efadd_pkg::MANT_W-1:0]  i_spec_mant,
    input  logic                          i_sub,
    input  logic                          i_sign,
    input  logic [efadd_pkg::EXP_W-1:0]   i_exp,
    input  logic [efadd_pkg::MANT_W-1:0]  i_sum,
    output efadd_pkg::t_out               o_out
);
    import efadd_pkg::*;

    logic [MANT_W-1:0] m;
    logic [EXP_W:0] e1;
    logic [7:0] lz, sh;

    always_comb begin
        m = i_sum;
        sh = '0;
        lz = 8'd159;
        for (int k = 0; k < 159; k++) begin
            if (i_sum[158-k] && lz == 8'd159) begin
                lz = 8'(k);
            end
        end
        e1 = {1'b0, i_exp};
        if (i_special) begin
            m = i_spec_mant;
        end else if (i_sub) begin
            if (i_sum[159]) begin
                sh = '0;
            end else begin
                if (i_exp < 15'd256 && i_exp[7:0] < lz) sh = i_exp[7:0];
                else sh = lz;
            end
            m = i_sum << sh;
            e1 = {1'b0, i_exp} - (EXP_W+1)'(sh);
        end else if (i_sum[159]) begin
            m = (i_sum >> 1) | (MANT_W'(1) << 158);
            e1 = {1'b0, i_exp} + 1'b1;
            if (e1 >= 16'h7FFF) begin
                e1 = 16'h7FFF;
                m = '0;
            end
        end
        o_out.sum_sign = i_sign;
        o_out.sum_exp = e1[EXP_W-1:0];
        o_out.sum_mant_hi = m[159:128];
        o_out.sum_mant_mid = m[127:64];
        o_out.sum_mant_lo = m[63:0];
    end

endmodule

// ===== src/extended_float_adder.sv =====
// Extended float adder: four-stage pipeline, one operation per clock when
// not stalled by i_ready. Stages from input beat to output beat: classify and swap,
// align shift, 160-bit add or subtract, normalize. Each stage advances when
// the output register ahead of it is empty or being taken; no rounding is done.
module extended_float_adder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  efadd_pkg::t_in    i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output efadd_pkg::t_out   o_data
);
    import efadd_pkg::*;

    t_work w0, r_w1, r_w2, n_w2;
    logic [MANT_W-1:0] r_sum;
    logic r_v1, r_v2, r_v3, r_v4;
    logic r_sp3, r_sub3, r_sign3;
    logic [EXP_W-1:0] r_exp3;
    logic [MANT_W-1:0] r_spm3;
    t_out n_out, r_out;
    logic adv1, adv2, adv3, adv4;

    efadd_prep u_prep (.i_in(i_data), .o_work(w0));

    assign adv4 = !r_v4 || i_ready;
    assign adv3 = !r_v3 || adv4;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign o_ready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
        end
    end

    always_comb begin
        n_w2 = r_w1;
        n_w2.lesser = r_w1.flush ? '0 : (r_w1.lesser >> r_w1.shamt);
    end

    always_ff @(posedge i_clk) begin
        if (adv1) r_w1 <= w0;
        if (adv2) r_w2 <= n_w2;
        if (adv3) begin
            r_sum <= r_w2.sub ? (r_w2.big - r_w2.lesser) : (r_w2.big + r_w2.lesser);
            r_sp3 <= r_w2.special;
            r_spm3 <= r_w2.spec_mant;
            r_sub3 <= r_w2.sub;
            r_sign3 <= r_w2.sign;
            r_exp3 <= r_w2.exp;
        end
        if (adv4) r_out <= n_out;
    end

    efadd_norm u_norm (
        .i_special(r_sp3), .i_spec_mant(r_spm3), .i_sub(r_sub3), .i_sign(r_sign3),
        .i_exp(r_exp3), .i_sum(r_sum), .o_out(n_out)
    );

    assign o_valid = r_v4;
    assign o_data = r_out;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data)) else $error("output beat dropped");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !adv4 |=> r_v3) else $error("stage three lost a beat");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> o_ready) else $error("stall with empty first stage");

endmodule

// ===== tb/testbench.sv =====
// Testbench for extended_float_adder: directed table plus random operands, scoreboard check.
module testbench;
    import efadd_pkg::*;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   out_ready = 1'b0;
    t_in    in_beat = '0;
    logic   in_ready;
    logic   out_valid;
    t_out   out_beat;

    t_out   sum_queue[$];
    int     errors = 0;
    int     idle_cycles = 0;
    int     sent = 0;
    int     checked = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;

    localparam logic [159:0] LEAD = 160'h1 << 158;

    extended_float_adder dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_valid(in_valid),
        .o_ready(in_ready),
        .i_data (in_beat),
        .o_valid(out_valid),
        .i_ready(out_ready),
        .o_data (out_beat)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic t_out pack_sum(logic sgn, logic [14:0] ex, logic [159:0] m);
        t_out r;
        r.sum_sign     = sgn;
        r.sum_exp      = ex;
        r.sum_mant_hi  = m[159:128];
        r.sum_mant_mid = m[127:64];
        r.sum_mant_lo  = m[63:0];
        return r;
    endfunction

    function automatic t_out add_extended(t_in x);
        logic         sa, sb, sub, a_nan, b_nan, a_inf, b_inf, a_big;
        logic [14:0]  ea, eb, es;
        logic [159:0] ma, mb, ms;
        logic [160:0] wide;
        int           d;
        sa = x.a_sign; ea = x.a_exp; ma = {x.a_mant_hi, x.a_mant_mid, x.a_mant_lo};
        sb = x.b_sign; eb = x.b_exp; mb = {x.b_mant_hi, x.b_mant_mid, x.b_mant_lo};
        sub = sa != sb;
        a_nan = ea == EXP_INF && ma != 0;
        b_nan = eb == EXP_INF && mb != 0;
        a_inf = ea == EXP_INF && ma == 0;
        b_inf = eb == EXP_INF && mb == 0;
        if (a_nan) return pack_sum(sa, ea, ma);
        if (b_nan) return pack_sum(sb, eb, mb);
        if (a_inf && b_inf && sub) return pack_sum(1'b0, EXP_INF, LEAD | (160'h1 << 63));
        if (a_inf || b_inf) return pack_sum(a_inf ? sa : sb, EXP_INF, '0);
        if (sub && ea == eb && ma == mb) return pack_sum(1'b0, '0, '0);
        a_big = ea > eb || (ea == eb && ma > mb);
        if (ea > eb) begin
            d = ea - eb;
            mb = d > 159 ? '0 : mb >> d;
            es = ea;
        end else begin
            d = eb - ea;
            ma = d > 159 ? '0 : ma >> d;
            es = eb;
        end
        if (sub) begin
            ms = a_big ? ma - mb : mb - ma;
            for (int k = 0; k < 159; k++) begin
                if (ms[159] || ms[158] || es == 0) break;
                ms = ms << 1;
                es = es - 1;
            end
            return pack_sum(a_big ? sa : sb, es, ms);
        end
        wide = {1'b0, ma} + {1'b0, mb};
        ms = wide[159:0];
        if (ms[159]) begin
            ms = (ms >> 1) | LEAD;
            if (es + 1 >= 32'(EXP_INF)) return pack_sum(sa, EXP_INF, '0);
            es = es + 1;
        end
        return pack_sum(sa, es, ms);
    endfunction

    function automatic t_in make_operands(logic sa, logic [14:0] ea, logic [159:0] ma,
                                          logic sb, logic [14:0] eb, logic [159:0] mb);
        t_in r;
        r.a_sign = sa; r.a_exp = ea;
        {r.a_mant_hi, r.a_mant_mid, r.a_mant_lo} = ma;
        r.b_sign = sb; r.b_exp = eb;
        {r.b_mant_hi, r.b_mant_mid, r.b_mant_lo} = mb;
        return r;
    endfunction

    function automatic logic [159:0] rand_mant(bit any_bits);
        logic [159:0] m;
        for (int i = 0; i < 5; i++) m[i*32 +: 32] = $urandom;
        if (!any_bits) begin
            m[159] = 1'b0;
            m[158] = 1'b1;
        end
        return m;
    endfunction

    function automatic logic [14:0] rand_exp();
        case ($urandom_range(0, 5))
            0: return 15'($urandom_range(0, 3));
            1: return 15'($urandom_range(32760, 32767));
            2: return 15'($urandom);
            default: return 15'(16000 + $urandom_range(0, 200));
        endcase
    endfunction

    function automatic t_in rand_operands();
        t_in          r;
        logic [14:0]  ea, eb;
        logic [159:0] ma, mb;
        ea = rand_exp();
        ma = rand_mant($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 7))
            0: eb = ea;
            1: eb = ea + 15'($urandom_range(0, 3));
            2: eb = 15'($urandom);
            default: eb = 15'(ea - $urandom_range(0, 170));
        endcase
        mb = rand_mant($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 9))
            0: mb = ma;
            1: mb = ma ^ (160'h1 << $urandom_range(0, 159));
            2: if (ea == EXP_INF) ma = '0;
            3: if (eb == EXP_INF) mb = '0;
            default: ;
        endcase
        r = make_operands($urandom_range(0, 1), ea, ma, $urandom_range(0, 1), eb, mb);
        return r;
    endfunction

    task automatic send_beat(t_in x);
        while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= x;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sum_queue.push_back(add_extended(x));
        sent++;
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (sum_queue.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    t_out e;
                    e = sum_queue.pop_front();
                    checked++;
                    if (out_beat.sum_sign !== e.sum_sign) begin
                        $error("sum_sign exp %0h got %0h", e.sum_sign, out_beat.sum_sign);
                        errors++;
                    end
                    if (out_beat.sum_exp !== e.sum_exp) begin
                        $error("sum_exp exp %0h got %0h", e.sum_exp, out_beat.sum_exp);
                        errors++;
                    end
                    if (out_beat.sum_mant_hi !== e.sum_mant_hi) begin
                        $error("sum_mant_hi exp %0h got %0h", e.sum_mant_hi,
                               out_beat.sum_mant_hi);
                        errors++;
                    end
                    if (out_beat.sum_mant_mid !== e.sum_mant_mid) begin
                        $error("sum_mant_mid exp %0h got %0h", e.sum_mant_mid,
                               out_beat.sum_mant_mid);
                        errors++;
                    end
                    if (out_beat.sum_mant_lo !== e.sum_mant_lo) begin
                        $error("sum_mant_lo exp %0h got %0h", e.sum_mant_lo,
                               out_beat.sum_mant_lo);
                        errors++;
                    end
                end
            end
            out_ready <= !(recv_stall_pct > 0 && $urandom_range(1, 100) <= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("** extended_float_adder: FAILED **");
            $finish;
        end
    end

    typedef struct {
        t_in  op;
        bit   known;
        t_out sum;
    } t_row;

    t_row rows[$];

    initial begin
        logic [159:0] half;
        half = LEAD;
        // directed table
        rows.push_back('{make_operands(0, 16383, half, 0, 16383, half), 1,
                         pack_sum(0, 16384, half)});
        rows.push_back('{make_operands(0, 16383, half, 1, 16383, half), 1,
                         pack_sum(0, 0, 0)});
        rows.push_back('{make_operands(0, EXP_INF, 0, 1, EXP_INF, 0), 1,
                         pack_sum(0, EXP_INF, LEAD | (160'h1 << 63))});
        rows.push_back('{make_operands(1, EXP_INF, 0, 1, EXP_INF, 0), 1,
                         pack_sum(1, EXP_INF, 0)});
        rows.push_back('{make_operands(1, EXP_INF, 0, 0, 5, half), 1,
                         pack_sum(1, EXP_INF, 0)});
        rows.push_back('{make_operands(0, 7, half, 1, EXP_INF, 0), 1,
                         pack_sum(1, EXP_INF, 0)});
        rows.push_back('{make_operands(1, EXP_INF, 160'h5, 0, EXP_INF, 160'h9), 1,
                         pack_sum(1, EXP_INF, 160'h5)});
        rows.push_back('{make_operands(0, 3, half, 1, EXP_INF, {160{1'b1}}), 1,
                         pack_sum(1, EXP_INF, {160{1'b1}})});
        rows.push_back('{make_operands(0, 32766, half, 0, 32766, half), 1,
                         pack_sum(0, EXP_INF, 0)});
        rows.push_back('{make_operands(0, 0, 0, 0, 0, 0), 1, pack_sum(0, 0, 0)});
        rows.push_back('{make_operands(1, 0, 0, 1, 0, 0), 1, pack_sum(1, 0, 0)});
        rows.push_back('{make_operands(0, 200, half, 0, 40, {160{1'b1}}), 0, '0});
        rows.push_back('{make_operands(0, 200, half, 0, 41, {160{1'b1}}), 0, '0});
        rows.push_back('{make_operands(1, 100, half, 0, 100, half | 160'h1), 0, '0});
        rows.push_back('{make_operands(0, 2, half, 1, 2, half | 160'h3), 0, '0});
        rows.push_back('{make_operands(0, 30000, {160{1'b1}}, 0, 30000, {160{1'b1}}), 0, '0});
        rows.push_back('{make_operands(1, 500, half, 0, 499, {160{1'b1}}), 0, '0});
        rows.push_back('{make_operands(0, 32766, {160{1'b1}}, 1, 1, half), 0, '0});

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        out_ready <= 1'b1;
        @(posedge clk);

        foreach (rows[i]) begin
            if (rows[i].known && add_extended(rows[i].op) !== rows[i].sum) begin
                $error("table row %0d: predictor disagrees with typed sum", i);
                errors++;
            end
            send_beat(rows[i].op);
        end

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                3: begin send_idle_pct = 10; recv_stall_pct = 10; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int n = 0; n < 205; n++) begin
                send_beat(rand_operands());
                if (n == 100 && phase == 3) begin
                    in_valid <= 1'b0;
                    while (sum_queue.size() != 0) @(posedge clk);
                end
            end
        end

        in_valid <= 1'b0;
        while (sum_queue.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Sent %0d operand pairs, checked %0d sums across NaN, infinity,", sent, checked);
        $display("cancellation, carry-out and alignment cases under varied flow control.");
        if (errors == 0) $display("** extended_float_adder: PASSED **");
        else $display("** extended_float_adder: FAILED **");
        $finish;
    end
endmodule
